// ----- sv/phtp_pkg.sv -----
`timescale 1ns / 1ps
// Types, codes and helper functions for the PES header timestamp parser.
// No dependencies; every other file refers to this package by scoped names.
package phtp_pkg;

  localparam int TS_W  = 33;
  localparam int POS_W = 9;

  typedef logic [TS_W-1:0]  ts_t;
  typedef logic [POS_W-1:0] pos_t;

  // result status codes
  localparam logic [1:0] ST_OK_NO_TS = 2'd0;
  localparam logic [1:0] ST_OK_TS    = 2'd1;
  localparam logic [1:0] ST_CORRUPT  = 2'd2;

  // PTS_DTS flag codes
  localparam logic [1:0] MODE_PTS_ONLY = 2'd2;
  localparam logic [1:0] MODE_PTS_DTS  = 2'd3;

  // byte positions within the optional header
  localparam pos_t POS_MARKER = 9'd0;
  localparam pos_t POS_FLAGS  = 9'd1;
  localparam pos_t POS_LENGTH = 9'd2;
  localparam pos_t POS_PTS0   = 9'd3;
  localparam pos_t POS_DTS0   = 9'd8;
  localparam pos_t POS_END    = 9'd13;
  localparam pos_t POS_MAX    = 9'h1ff;

  localparam logic [7:0] MARKER_MASK     = 8'hc0;
  localparam logic [7:0] MARKER_VALUE    = 8'h80;
  localparam logic [2:0] HIGH_TS_BITS    = 3'h7;
  localparam logic [7:0] MIN_LEN_PTS_DTS = 8'd10;
  localparam logic [7:0] MIN_LEN_PTS     = 8'd5;
  localparam pos_t       HDR_FIXED       = 9'd3;
  localparam ts_t        GAP_RESET       = 33'd180000;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       first_byte;
    logic       last_byte;
    logic       stream_errored;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] header_bytes;
    logic       pts_valid;
    ts_t        pts;
    logic       dts_valid;
    ts_t        dts;
  } result_t;

  // Bits that one byte of a 3/15/15 timestamp group contributes.
  function automatic ts_t gather_bits(input logic [2:0] k, input logic [7:0] b);
    ts_t r;
    r = '0;
    case (k)
      3'd0: begin
        r[32:30] = b[3:1] & HIGH_TS_BITS;
      end
      3'd1: begin
        r[29:22] = b;
      end
      3'd2: begin
        r[21:15] = b[7:1];
      end
      3'd3: begin
        r[14:7] = b;
      end
      default: begin
        r[6:0] = b[7:1];
      end
    endcase
    return r;
  endfunction

  // Group bytes 0, 2 and 4 carry a marker bit in bit 0.
  function automatic logic has_marker(input logic [2:0] k);
    return (k == 3'd0) || (k == 3'd2) || (k == 3'd4);
  endfunction

endpackage

// ----- sv/phtp_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for header bytes in and parse results out.
// Depends on phtp_pkg for the timestamp type.
interface phtp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       first_byte;
  logic       last_byte;
  logic       stream_errored;

  modport source (output valid, header_byte, first_byte, last_byte, stream_errored,
                  input ready);
  modport sink (input valid, header_byte, first_byte, last_byte, stream_errored,
                output ready);
endinterface

interface phtp_result_if;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [8:0]       header_bytes;
  logic             pts_valid;
  phtp_pkg::ts_t    pts;
  logic             dts_valid;
  phtp_pkg::ts_t    dts;

  modport source (output valid, status, header_bytes, pts_valid, pts, dts_valid, dts,
                  input ready);
  modport sink (input valid, status, header_bytes, pts_valid, pts, dts_valid, dts,
                output ready);
endinterface

// ----- sv/phtp_core.sv -----
`timescale 1ns / 1ps
// Header parse state and per-byte result logic.
// Depends on phtp_pkg.
module phtp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  phtp_pkg::in_word_t word,
  input  phtp_pkg::ts_t      max_gap,
  output logic               res_valid,
  output phtp_pkg::result_t  res
);

  phtp_pkg::pos_t pos_r, pos_nxt, pos_e;
  logic [7:0]     len_r, len_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic           mko_r, mko_nxt;
  phtp_pkg::ts_t  pg_r, pg_nxt, pg_e;
  phtp_pkg::ts_t  dg_r, dg_nxt, dg_e;
  logic           pm_r, pm_nxt, pm_e;
  logic           dm_r, dm_nxt, dm_e;
  logic           fin_r, fin_nxt, fin_e;

  logic           active, hdr_fail, done, corrupt;
  logic [2:0]     k_pts, k_dts;
  phtp_pkg::ts_t  gap, p_sel, d_sel;
  logic           pv, dv;
  phtp_pkg::pos_t end_pos;

  assign k_pts   = 3'(pos_e - phtp_pkg::POS_PTS0);
  assign k_dts   = 3'(pos_e - phtp_pkg::POS_DTS0);
  assign end_pos = {1'b0, len_nxt} + phtp_pkg::POS_LENGTH;
  assign gap     = pg_nxt - dg_nxt;

  always_comb begin
    // a first byte restarts the header
    pos_e = word.first_byte ? '0    : pos_r;
    fin_e = word.first_byte ? 1'b0  : fin_r;
    pg_e  = word.first_byte ? '0    : pg_r;
    dg_e  = word.first_byte ? '0    : dg_r;
    pm_e  = word.first_byte ? 1'b1  : pm_r;
    dm_e  = word.first_byte ? 1'b1  : dm_r;
    active = !fin_e;

    pos_nxt  = pos_e;
    len_nxt  = len_r;
    mode_nxt = mode_r;
    mko_nxt  = mko_r;
    pg_nxt   = pg_e;
    dg_nxt   = dg_e;
    pm_nxt   = pm_e;
    dm_nxt   = dm_e;
    fin_nxt  = fin_e;

    if (active) begin
      if (pos_e == phtp_pkg::POS_MARKER) begin
        mko_nxt = (word.header_byte & phtp_pkg::MARKER_MASK) == phtp_pkg::MARKER_VALUE;
      end else if (pos_e == phtp_pkg::POS_FLAGS) begin
        mode_nxt = word.header_byte[7:6];
      end else if (pos_e == phtp_pkg::POS_LENGTH) begin
        len_nxt = word.header_byte;
      end else if (pos_e < phtp_pkg::POS_DTS0) begin
        pg_nxt = pg_e | phtp_pkg::gather_bits(k_pts, word.header_byte);
        if (phtp_pkg::has_marker(k_pts)) begin
          pm_nxt = pm_e & word.header_byte[0];
        end
      end else if (pos_e < phtp_pkg::POS_END) begin
        dg_nxt = dg_e | phtp_pkg::gather_bits(k_dts, word.header_byte);
        if (phtp_pkg::has_marker(k_dts)) begin
          dm_nxt = dm_e & word.header_byte[0];
        end
      end
      if (pos_e != phtp_pkg::POS_MAX) begin
        pos_nxt = pos_e + 9'd1;
      end
    end

    hdr_fail = (pos_e == phtp_pkg::POS_LENGTH) &&
               (!mko_nxt ||
                ((mode_nxt == phtp_pkg::MODE_PTS_DTS) && (len_nxt < phtp_pkg::MIN_LEN_PTS_DTS)) ||
                ((mode_nxt == phtp_pkg::MODE_PTS_ONLY) && (len_nxt < phtp_pkg::MIN_LEN_PTS)));
    if (pos_e == phtp_pkg::POS_LENGTH) begin
      done = len_nxt == 8'd0;
    end else begin
      done = (pos_e >= phtp_pkg::POS_PTS0) && (pos_e == end_pos);
    end
    corrupt   = hdr_fail || !done;
    res_valid = active && (hdr_fail || done || word.last_byte);
    if (res_valid) begin
      fin_nxt = 1'b1;
    end

    // result fields
    pv    = 1'b0;
    dv    = 1'b0;
    p_sel = pg_nxt;
    d_sel = dg_nxt;
    res   = '0;
    if (corrupt) begin
      res.status = phtp_pkg::ST_CORRUPT;
    end else begin
      res.header_bytes = {1'b0, len_nxt} + phtp_pkg::HDR_FIXED;
      if (mode_nxt == phtp_pkg::MODE_PTS_DTS) begin
        pv = pm_nxt;
        dv = dm_nxt;
        if (pv && dv && (gap > max_gap)) begin
          pv = 1'b0;
          dv = 1'b0;
        end
        res.status = phtp_pkg::ST_OK_TS;
      end else if (mode_nxt == phtp_pkg::MODE_PTS_ONLY) begin
        pv    = pm_nxt;
        dv    = pm_nxt;
        d_sel = pg_nxt;
        res.status = phtp_pkg::ST_OK_TS;
      end else begin
        res.status = phtp_pkg::ST_OK_NO_TS;
      end
      if (word.stream_errored) begin
        pv = 1'b0;
        dv = 1'b0;
      end
      res.pts_valid = pv;
      res.dts_valid = dv;
      res.pts       = pv ? p_sel : '0;
      res.dts       = dv ? d_sel : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      len_r  <= '0;
      mode_r <= '0;
      mko_r  <= 1'b0;
      pg_r   <= '0;
      dg_r   <= '0;
      pm_r   <= 1'b0;
      dm_r   <= 1'b0;
      fin_r  <= 1'b1;
    end else if (step) begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      mode_r <= mode_nxt;
      mko_r  <= mko_nxt;
      pg_r   <= pg_nxt;
      dg_r   <= dg_nxt;
      pm_r   <= pm_nxt;
      dm_r   <= dm_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

// ----- sv/phtp_out_reg.sv -----
`timescale 1ns / 1ps
// Result register driving the output channel.
// Depends on phtp_pkg and phtp_result_if.
module phtp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  phtp_pkg::result_t res,
  output logic              out_free,
  phtp_result_if.source     out_bus
);

  logic              valid_r, valid_nxt;
  phtp_pkg::result_t res_r;

  assign out_free = !valid_r || out_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_bus.valid        = valid_r;
  assign out_bus.status       = res_r.status;
  assign out_bus.header_bytes = res_r.header_bytes;
  assign out_bus.pts_valid    = res_r.pts_valid;
  assign out_bus.pts          = res_r.pts;
  assign out_bus.dts_valid    = res_r.dts_valid;
  assign out_bus.dts          = res_r.dts;

endmodule

// ----- sv/pes_header_timestamp_parser.sv -----
`timescale 1ns / 1ps
// Top level of the PES optional-header PTS/DTS parser.
// Depends on phtp_pkg, phtp_ifs, phtp_core and phtp_out_reg.
//
// Usage notes:
//  - in_bus takes one header byte per word, starting at the marker/flags byte
//    (first_byte set). last_byte flags the final byte available in the packet;
//    stream_errored is sampled on the byte that completes the header.
//  - out_bus gives at most one result word per header: status, total header
//    length, and PTS/DTS with their valid flags. Bytes after the result are
//    dropped until the next first_byte.
//  - cfg_wr_en/cfg_wr_data load the 33-bit PTS-DTS gap limit (reset 180000);
//    write only while the parser is idle.
//  - Path: an accepted byte goes into the input register, then through the parse
//    logic into the result register that drives out_bus.
//  - Throughput: one byte per cycle while out_bus.ready is high; the 33-bit
//    gap subtract-and-compare is the longest path.
//  - When the receiver stalls, one more byte is still taken into the input
//    register, then in_bus.ready drops until the result word is taken.
//  - Reset (rst_n low, synchronous) empties both registers and leaves the
//    parser idle, waiting for a first byte.
module pes_header_timestamp_parser (
  input  logic          clk,
  input  logic          rst_n,
  phtp_byte_if.sink     in_bus,
  phtp_result_if.source out_bus,
  input  logic          cfg_wr_en,
  input  phtp_pkg::ts_t cfg_wr_data
);

  phtp_pkg::ts_t      gap_r;
  logic               s1_valid_r, s1_valid_nxt;
  phtp_pkg::in_word_t s1_word_r;
  logic               out_free, step, accept, res_valid;
  phtp_pkg::result_t  res;

  assign in_bus.ready = !s1_valid_r || out_free;
  assign accept       = in_bus.valid && in_bus.ready;
  assign step         = s1_valid_r && out_free;

  // gap limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= phtp_pkg::GAP_RESET;
    end else if (cfg_wr_en) begin
      gap_r <= cfg_wr_data;
    end
  end

  // input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r.header_byte    <= in_bus.header_byte;
      s1_word_r.first_byte     <= in_bus.first_byte;
      s1_word_r.last_byte      <= in_bus.last_byte;
      s1_word_r.stream_errored <= in_bus.stream_errored;
    end
  end

  phtp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word      (s1_word_r),
    .max_gap   (gap_r),
    .res_valid (res_valid),
    .res       (res)
  );

  phtp_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step && res_valid),
    .res      (res),
    .out_free (out_free),
    .out_bus  (out_bus)
  );

  // a new result word only ever follows a parse step
  a_rise_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(step))
    else $error("result word appeared without a parse step");

  // an empty input register must never hold off the sender
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_bus.ready)
    else $error("input blocked with empty input register");

  a_corrupt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (out_bus.status == phtp_pkg::ST_CORRUPT)) |->
      ((out_bus.header_bytes == 9'd0) && !out_bus.pts_valid && !out_bus.dts_valid))
    else $error("corrupt result carries length or timestamps");

  a_ts_needs_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (out_bus.pts_valid || out_bus.dts_valid)) |->
      (out_bus.status == phtp_pkg::ST_OK_TS))
    else $error("valid timestamp without timestamp status");

endmodule

// ----- tb/tb_pes_header_timestamp_parser.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pes_header_timestamp_parser: PES header bytes in, results out.
// Depends on phtp_pkg, phtp_ifs and the parser RTL; a result tracker class predicts and checks.

class header_result_checker;
  phtp_pkg::result_t expected_results[$];
  phtp_pkg::ts_t     gap_limit;
  int                errors;
  // tracked parser state
  phtp_pkg::pos_t    pos;
  logic [7:0]        hdr_len;
  logic [1:0]        ts_mode;
  bit                marker_good;
  bit                pts_marks_good;
  bit                dts_marks_good;
  bit                parser_idle;
  phtp_pkg::ts_t     pts_bits;
  phtp_pkg::ts_t     dts_bits;

  function new();
    gap_limit      = phtp_pkg::GAP_RESET;
    errors         = 0;
    pos            = '0;
    hdr_len        = '0;
    ts_mode        = '0;
    marker_good    = 0;
    pts_marks_good = 0;
    dts_marks_good = 0;
    pts_bits       = '0;
    dts_bits       = '0;
    parser_idle    = 1;
  endfunction

  function void load_gap(phtp_pkg::ts_t v);
    gap_limit = v;
  endfunction

  function int waiting();
    return expected_results.size();
  endfunction

  function void post(logic [1:0] st, logic [8:0] nbytes, bit pv, phtp_pkg::ts_t p, bit dv,
                     phtp_pkg::ts_t d);
    phtp_pkg::result_t r;
    r.status       = st;
    r.header_bytes = nbytes;
    r.pts_valid    = pv;
    r.pts          = pv ? p : '0;
    r.dts_valid    = dv;
    r.dts          = dv ? d : '0;
    expected_results.push_back(r);
    parser_idle = 1;
  endfunction

  // 3/15/15 layout: marker bit sits in bit 0 of group bytes 0, 2 and 4
  function void fold(bit into_dts, int k, logic [7:0] b);
    phtp_pkg::ts_t part;
    bit            marked;
    marked = (k == 0) || (k == 2) || (k == 4);
    case (k)
      0:       part = phtp_pkg::ts_t'(b[3:1]) << 30;
      1:       part = phtp_pkg::ts_t'(b) << 22;
      2:       part = phtp_pkg::ts_t'(b[7:1]) << 15;
      3:       part = phtp_pkg::ts_t'(b) << 7;
      default: part = phtp_pkg::ts_t'(b[7:1]);
    endcase
    if (into_dts) begin
      dts_bits = dts_bits | part;
      if (marked) dts_marks_good = dts_marks_good & b[0];
    end else begin
      pts_bits = pts_bits | part;
      if (marked) pts_marks_good = pts_marks_good & b[0];
    end
  endfunction

  // Returns 1 when the parser acts on the word, 0 when it is dropped while idle.
  function bit take_byte(phtp_pkg::in_word_t w);
    phtp_pkg::pos_t idx;
    bit             done;
    bit             pv;
    bit             dv;
    phtp_pkg::ts_t  p;
    phtp_pkg::ts_t  d;
    logic [8:0]     nbytes;
    if (w.first_byte) begin
      pos            = '0;
      parser_idle    = 0;
      pts_bits       = '0;
      dts_bits       = '0;
      pts_marks_good = 1;
      dts_marks_good = 1;
    end
    if (parser_idle) return 0;
    idx  = pos;
    done = 0;
    if (idx == phtp_pkg::POS_MARKER)
      marker_good = (w.header_byte & phtp_pkg::MARKER_MASK) == phtp_pkg::MARKER_VALUE;
    else if (idx == phtp_pkg::POS_FLAGS) ts_mode = w.header_byte[7:6];
    else if (idx == phtp_pkg::POS_LENGTH) hdr_len = w.header_byte;
    else if (idx < phtp_pkg::POS_DTS0)
      fold(0, int'(idx - phtp_pkg::POS_PTS0), w.header_byte);
    else if (idx < phtp_pkg::POS_END)
      fold(1, int'(idx - phtp_pkg::POS_DTS0), w.header_byte);
    if (pos != phtp_pkg::POS_MAX) pos = pos + 1'b1;

    if (idx == phtp_pkg::POS_LENGTH) begin
      if (!marker_good ||
          (ts_mode == phtp_pkg::MODE_PTS_DTS && hdr_len < phtp_pkg::MIN_LEN_PTS_DTS) ||
          (ts_mode == phtp_pkg::MODE_PTS_ONLY && hdr_len < phtp_pkg::MIN_LEN_PTS)) begin
        post(phtp_pkg::ST_CORRUPT, '0, 0, '0, 0, '0);
        return 1;
      end
      done = hdr_len == 8'd0;
    end else if (idx > phtp_pkg::POS_LENGTH) begin
      done = idx == ({1'b0, hdr_len} + phtp_pkg::POS_LENGTH);
    end

    if (!done) begin
      if (w.last_byte) post(phtp_pkg::ST_CORRUPT, '0, 0, '0, 0, '0);
      return 1;
    end

    nbytes = {1'b0, hdr_len} + phtp_pkg::HDR_FIXED;
    if (ts_mode != phtp_pkg::MODE_PTS_DTS && ts_mode != phtp_pkg::MODE_PTS_ONLY) begin
      post(phtp_pkg::ST_OK_NO_TS, nbytes, 0, '0, 0, '0);
      return 1;
    end
    p  = pts_bits;
    pv = pts_marks_good;
    if (ts_mode == phtp_pkg::MODE_PTS_DTS) begin
      d  = dts_bits;
      dv = dts_marks_good;
      if (pv && dv && phtp_pkg::ts_t'(p - d) > gap_limit) begin
        pv = 0;
        dv = 0;
      end
    end else begin
      d  = p;
      dv = pv;
    end
    if (w.stream_errored) begin
      pv = 0;
      dv = 0;
    end
    post(phtp_pkg::ST_OK_TS, nbytes, pv, p, dv, d);
    return 1;
  endfunction

  function void check_result(phtp_pkg::result_t got);
    phtp_pkg::result_t want;
    if (expected_results.size() == 0) begin
      if (errors < 10)
        $display("unexpected result: status=%0d bytes=%0d pts=%0b:%h dts=%0b:%h",
                 got.status, got.header_bytes, got.pts_valid, got.pts, got.dts_valid, got.dts);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status || got.header_bytes !== want.header_bytes ||
        got.pts_valid !== want.pts_valid || got.pts !== want.pts ||
        got.dts_valid !== want.dts_valid || got.dts !== want.dts) begin
      if (errors < 10) begin
        $display("result mismatch: expected status=%0d bytes=%0d pts=%0b:%h dts=%0b:%h",
                 want.status, want.header_bytes, want.pts_valid, want.pts,
                 want.dts_valid, want.dts);
        $display("                 actual   status=%0d bytes=%0d pts=%0b:%h dts=%0b:%h",
                 got.status, got.header_bytes, got.pts_valid, got.pts, got.dts_valid, got.dts);
      end
      errors++;
    end
  endfunction
endclass

module tb_pes_header_timestamp_parser;

  localparam int            CYCLE_LIMIT   = 200000;
  localparam int            SETTLE_CYCLES = 4;      // two-stage latency plus margin
  localparam int            RANDOM_BYTES  = 1000;
  localparam int            NUM_PHASES    = 5;
  localparam int            LONG_HOLD     = 300;
  localparam phtp_pkg::ts_t TS_MAX        = '1;
  // flag codes with no timestamps (the package names only the two that carry them)
  localparam logic [1:0]    MODE_NONE     = 2'd0;
  localparam logic [1:0]    MODE_RESERVED = 2'd1;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          cfg_wr_en;
  phtp_pkg::ts_t cfg_wr_data;
  int unsigned   cycle_count = 0;

  // rx_hold and burst are shared between the sender and the receiver process
  int          rx_hold = 0;     // one-off long stall request for the receiver
  bit          burst = 0;       // no idling on either side while set
  int          used_bytes = 0;  // words the parser acted on, ignored ones left out

  header_result_checker tracker;
  phtp_pkg::in_word_t   pkt[$];

  phtp_byte_if   in_if ();
  phtp_result_if out_if ();

  pes_header_timestamp_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_if),
    .out_bus    (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Hard stop: well clear of the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic phtp_pkg::ts_t rand_ts();
    phtp_pkg::ts_t t;
    t = {1'($urandom), 32'($urandom)};
    return t;
  endfunction

  // PTS-minus-DTS distance to build a header around: sits on, just over and
  // just under the current limit, plus small, random and wrapped distances.
  function automatic phtp_pkg::ts_t pick_distance();
    case ($urandom_range(0, 5))
      0:       return tracker.gap_limit;
      1:       return tracker.gap_limit + 1'b1;
      2:       return tracker.gap_limit - 1'b1;
      3:       return phtp_pkg::ts_t'($urandom_range(0, 1000));
      4:       return rand_ts();
      default: return TS_MAX;   // DTS one tick ahead of PTS
    endcase
  endfunction

  // One byte of a timestamp group; kill 1..3 clears the marker of group byte 0, 2 or 4.
  function automatic logic [7:0] stamp_byte(phtp_pkg::ts_t ts, int k, int kill);
    case (k)
      0:       return {4'($urandom), ts[32:30], 1'(kill != 1)};
      1:       return ts[29:22];
      2:       return {ts[21:15], 1'(kill != 2)};
      3:       return ts[14:7];
      default: return {ts[6:0], 1'(kill != 3)};
    endcase
  endfunction

  function automatic void add(logic [7:0] b, bit first, bit last, bit err);
    phtp_pkg::in_word_t w;
    w.header_byte    = b;
    w.first_byte     = first;
    w.last_byte      = last;
    w.stream_errored = err;
    pkt.push_back(w);
  endfunction

  // Queue a header of len+3 bytes. keep in 1..len+2 cuts it short after keep bytes,
  // flagging last_byte on the cut when cut_last is set (else it is abandoned).
  function automatic void add_header(logic [1:0] mode, int len, bit marker_ok,
                                     phtp_pkg::ts_t pts, phtp_pkg::ts_t dts,
                                     int pts_kill, int dts_kill, bit err,
                                     int keep, bit cut_last);
    int         total;
    int         n;
    logic [7:0] b;
    total = len + 3;
    n     = (keep > 0 && keep < total) ? keep : total;
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        b = 8'($urandom);
        if (marker_ok) b = (b & ~phtp_pkg::MARKER_MASK) | phtp_pkg::MARKER_VALUE;
        else if ((b & phtp_pkg::MARKER_MASK) == phtp_pkg::MARKER_VALUE) b = b ^ 8'h40;
      end else if (i == 1) begin
        b = {mode, 6'($urandom)};
      end else if (i == 2) begin
        b = 8'(len);
      end else if (i < 8) begin
        b = stamp_byte(pts, i - 3, pts_kill);
      end else if (i < 13) begin
        b = stamp_byte(dts, i - 8, dts_kill);
      end else begin
        b = 8'($urandom);   // stuffing
      end
      // last_byte on a completing byte changes nothing, so it is left to chance
      add(b, i == 0, (i == n - 1) && (n < total ? cut_last : 1'($urandom)), err);
    end
  endfunction

  // Offer one word and wait for it to be taken. valid stays high when the
  // next word follows straight on.
  task automatic send_word(phtp_pkg::in_word_t w);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.header_byte    <= w.header_byte;
    in_if.first_byte     <= w.first_byte;
    in_if.last_byte      <= w.last_byte;
    in_if.stream_errored <= w.stream_errored;
    do @(posedge clk); while (!in_if.ready);
    if (tracker.take_byte(w)) used_bytes++;
  endtask

  task automatic send_packet();
    while (pkt.size() > 0) send_word(pkt.pop_front());
  endtask

  // Stop offering and wait until every expected result is out, then give any
  // word still in the pipeline that makes no result time to pass through.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap(phtp_pkg::ts_t v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.load_gap(v);
  endtask

  // Mostly well-formed headers with random content; some broken on purpose.
  task automatic random_header();
    logic [1:0]    mode;
    int            len;
    int            lo;
    int            sel;
    int            keep;
    int            pk;
    int            dk;
    bit            cut_last;
    bit            mk;
    phtp_pkg::ts_t pts;
    phtp_pkg::ts_t dts;
    sel = $urandom_range(0, 99);
    if (sel < 50) mode = phtp_pkg::MODE_PTS_DTS;
    else if (sel < 75) mode = phtp_pkg::MODE_PTS_ONLY;
    else if (sel < 88) mode = MODE_NONE;
    else mode = MODE_RESERVED;
    lo  = (mode == phtp_pkg::MODE_PTS_DTS) ? 10 : (mode == phtp_pkg::MODE_PTS_ONLY) ? 5 : 0;
    len = lo + $urandom_range(0, 6);
    if ($urandom_range(0, 29) == 0) len = $urandom_range(lo, 255);
    if (lo > 0 && $urandom_range(0, 9) == 0) len = $urandom_range(0, lo - 1);
    mk  = $urandom_range(0, 11) != 0;
    pts = rand_ts();
    dts = pts - pick_distance();
    pk  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    dk  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    keep     = 0;
    cut_last = 1;
    sel = $urandom_range(0, 23);
    if (sel < 3) begin
      keep = $urandom_range(1, len + 2);
    end else if (sel < 5) begin
      keep     = $urandom_range(1, len + 2);
      cut_last = 0;
    end
    add_header(mode, len, mk, pts, dts, pk, dk, $urandom_range(0, 5) == 0, keep, cut_last);
    // trailing bytes, dropped by the parser once the header is done
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) add(8'($urandom), 0, 1'($urandom), 1'($urandom));
    send_packet();
  endtask

  // Unstructured words, first_byte included now and then.
  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      add(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, 1'($urandom));
    send_packet();
  endtask

  // Receiver: takes result words, holding ready low for a random spell between
  // them (never while burst is set), or for a long stretch when asked.
  initial begin
    phtp_pkg::result_t got;
    int                n;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_if.ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!out_if.valid);
      got.status       = out_if.status;
      got.header_bytes = out_if.header_bytes;
      got.pts_valid    = out_if.pts_valid;
      got.pts          = out_if.pts;
      got.dts_valid    = out_if.dts_valid;
      got.dts          = out_if.dts;
      tracker.check_result(got);
      if (rx_hold > 0) begin
        n       = rx_hold;
        rx_hold = 0;
      end else begin
        n = burst ? 0 : $urandom_range(0, 3);
      end
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed headers, then random phases each under its own gap limit.
  initial begin
    int            target;
    int            mid;
    bit            held;
    bit            paused;
    phtp_pkg::ts_t gap;
    tracker = new();
    held    = 0;
    paused  = 0;
    rst_n                <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    in_if.valid          <= 1'b0;
    in_if.header_byte    <= '0;
    in_if.first_byte     <= 1'b0;
    in_if.last_byte      <= 1'b0;
    in_if.stream_errored <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, limit still at its reset value ---
    // truncated on the marker byte, then on the flags byte
    add(phtp_pkg::MARKER_VALUE, 1, 1, 0);
    add_header(phtp_pkg::MODE_PTS_DTS, 10, 1, '0, '0, 0, 0, 0, 2, 1);
    // bad marker bits
    add_header(phtp_pkg::MODE_PTS_ONLY, 5, 0, rand_ts(), '0, 0, 0, 0, 0, 0);
    // declared length too short for the flagged timestamps
    add_header(phtp_pkg::MODE_PTS_DTS, 9, 1, rand_ts(), rand_ts(), 0, 0, 0, 0, 0);
    add_header(phtp_pkg::MODE_PTS_ONLY, 4, 1, rand_ts(), '0, 0, 0, 0, 0, 0);
    // no timestamps: empty header, then the reserved flag code
    add_header(MODE_NONE, 0, 1, '0, '0, 0, 0, 0, 0, 0);
    add_header(MODE_RESERVED, 2, 1, '0, '0, 0, 0, 0, 0, 0);
    // stray words while idle
    add(8'hff, 0, 0, 1);
    add(8'h00, 0, 1, 0);
    // header abandoned in the PTS, restarted by the next first byte
    add_header(phtp_pkg::MODE_PTS_DTS, 10, 1, TS_MAX, '0, 0, 0, 0, 6, 0);
    // distance exactly at the limit, then one tick over
    add_header(phtp_pkg::MODE_PTS_DTS, 10, 1, TS_MAX, TS_MAX - phtp_pkg::GAP_RESET,
               0, 0, 0, 0, 0);
    add_header(phtp_pkg::MODE_PTS_DTS, 10, 1, '0, '0 - phtp_pkg::GAP_RESET - 1'b1,
               0, 0, 0, 0, 0);
    // wrapped distance of one
    add_header(phtp_pkg::MODE_PTS_DTS, 10, 1, '0, TS_MAX, 0, 0, 0, 0, 0);
    // PTS only, all ones
    add_header(phtp_pkg::MODE_PTS_ONLY, 5, 1, TS_MAX, '0, 0, 0, 0, 0, 0);
    // bad PTS marker: no distance check, DTS kept
    add_header(phtp_pkg::MODE_PTS_DTS, 10, 1, '0, phtp_pkg::ts_t'(33'h1_0000_0000),
               2, 0, 0, 0, 0);
    // errored stream
    add_header(phtp_pkg::MODE_PTS_ONLY, 5, 1, rand_ts(), '0, 0, 0, 1, 0, 0);
    // truncated inside the DTS
    add_header(phtp_pkg::MODE_PTS_DTS, 12, 1, rand_ts(), rand_ts(), 0, 0, 0, 10, 1);
    // longest declared length
    add_header(phtp_pkg::MODE_PTS_DTS, 255, 1, rand_ts(), rand_ts(), 0, 0, 0, 0, 0);
    send_packet();

    // --- random phases ---
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0:       gap = '0;
        1:       gap = TS_MAX;
        2:       gap = phtp_pkg::GAP_RESET;
        3:       gap = rand_ts();
        default: gap = phtp_pkg::ts_t'($urandom_range(0, 5000));
      endcase
      write_gap(gap);
      target = used_bytes + RANDOM_BYTES / NUM_PHASES;
      mid    = used_bytes + RANDOM_BYTES / (2 * NUM_PHASES);
      while (used_bytes < target) begin
        if ($urandom_range(0, 9) == 0) burst = !burst;
        // receiver stalls long enough for the input side to back up
        if (ph == 1 && !held && used_bytes >= mid) begin
          rx_hold = LONG_HOLD;
          held    = 1;
        end
        // sender waits for the parser to empty out completely
        if (ph == 2 && !paused && used_bytes >= mid) begin
          drain();
          paused = 1;
        end
        if ($urandom_range(0, 14) == 0) noise_burst();
        else random_header();
      end
    end

    burst = 0;
    drain();
    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
